>>> src/dcr_pkg.sv
`timescale 1ns / 1ps

package dcr_pkg;

   // Largest packet handled; bytes beyond it are ignored.
   localparam int MAX_PACKET = 512;

   // Position counters must hold a label jump past the packet limit.
   localparam int POS_W = $clog2(MAX_PACKET + 272);
   typedef logic [POS_W-1:0] dcr_pos_type;

   // Header offsets of interest.
   localparam dcr_pos_type OFS_FLAGS_HI   = POS_W'(2);
   localparam dcr_pos_type OFS_FLAGS_LO   = POS_W'(3);
   localparam dcr_pos_type OFS_QDCOUNT_HI = POS_W'(4);
   localparam dcr_pos_type OFS_QDCOUNT_LO = POS_W'(5);
   localparam dcr_pos_type OFS_ANCOUNT_HI = POS_W'(6);
   localparam dcr_pos_type OFS_ANCOUNT_LO = POS_W'(7);
   localparam dcr_pos_type OFS_HDR_LAST   = POS_W'(11);
   localparam dcr_pos_type HDR_LEN        = POS_W'(12);
   localparam dcr_pos_type POS_MAX        = POS_W'(MAX_PACKET);

   // Type and class bytes after the root label, counted from the root label.
   localparam dcr_pos_type QTAIL_SPAN     = POS_W'(5);

   // Header constants.
   localparam logic [7:0] FLAG_QR      = 8'h80;
   localparam logic [7:0] ANCOUNT_ONE  = 8'h01;

   // Answer record.
   localparam int ANSWER_LEN = 16;
   localparam int ANS_IDX_W  = $clog2(ANSWER_LEN);
   typedef logic [ANS_IDX_W-1:0] dcr_ans_idx_type;
   localparam dcr_ans_idx_type ANS_IDX_LAST = ANS_IDX_W'(ANSWER_LEN - 1);
   localparam logic [7:0] ANS_PTR_HI   = 8'hC0;
   localparam logic [7:0] ANS_PTR_LO   = 8'h0C;
   localparam logic [7:0] ANS_TYPE_A   = 8'h01;
   localparam logic [7:0] ANS_CLASS_IN = 8'h01;
   localparam logic [7:0] ANS_RDLEN    = 8'h04;

   // Configuration registers.
   localparam int CSR_AW = 3;
   localparam logic REG_ANSWER_ADDRESS = 1'b0;
   localparam logic REG_ANSWER_TTL     = 1'b1;
   localparam logic [31:0] ANSWER_ADDRESS_RESET = 32'hC0A80401;
   localparam logic [31:0] ANSWER_TTL_RESET     = 32'd30;

   // Parser outcome for one accepted request.
   typedef struct packed {
      logic       pass_valid;
      logic [7:0] pass_byte;
      logic       last;
      logic       ok;
   } dcr_parse_type;

   // One reply item.
   typedef struct packed {
      logic [7:0] data;
      logic       eor;
      logic       drop;
   } dcr_item_type;

endpackage

>>> src/dcr_req_if.sv
`timescale 1ns / 1ps

interface dcr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> src/dcr_rsp_if.sv
`timescale 1ns / 1ps

interface dcr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_reply;
   logic       reply_dropped;

   modport source (output valid, output out_byte, output end_of_reply,
                   output reply_dropped, input ready);
   modport sink   (input valid, input out_byte, input end_of_reply,
                   input reply_dropped, output ready);
endinterface

>>> src/dcr_csr.sv
`timescale 1ns / 1ps

module dcr_csr
   import dcr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output logic [31:0]       answer_address,
   output logic [31:0]       answer_ttl
);

   logic [31:0] address_ff, address_in;
   logic [31:0] ttl_ff, ttl_in;
   logic        wr_en;

   // Write in the access phase; the port never inserts wait states.
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      address_in = address_ff;
      ttl_in     = ttl_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_ANSWER_ADDRESS: address_in = pwdata;
            REG_ANSWER_TTL:     ttl_in     = pwdata;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= ANSWER_ADDRESS_RESET;
         ttl_ff     <= ANSWER_TTL_RESET;
      end else begin
         address_ff <= address_in;
         ttl_ff     <= ttl_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (paddr[2])
         REG_ANSWER_ADDRESS: prdata = address_ff;
         REG_ANSWER_TTL:     prdata = ttl_ff;
         default:            prdata = '0;
      endcase
   end

   assign answer_address = address_ff;
   assign answer_ttl     = ttl_ff;

endmodule

>>> src/dcr_parser.sv
`timescale 1ns / 1ps

module dcr_parser
   import dcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   output dcr_parse_type parse
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_TAIL,
      PH_DONE,
      PH_REJECT
   } phase_type;

   phase_type   phase_ff, phase_in;
   dcr_pos_type pos_ff, pos_in;
   dcr_pos_type nlp_ff, nlp_in;
   dcr_pos_type qend_ff, qend_in;
   logic        qcz_ff, qcz_in;
   logic        pass_valid;
   logic [7:0]  pass_byte;
   logic        reply_ok;

   // Per-byte parse: header rewrite, label walk, question tail.
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      nlp_in     = nlp_ff;
      qend_in    = qend_ff;
      qcz_in     = qcz_ff;
      pass_valid = 1'b0;
      pass_byte  = in_byte;
      if (pos_ff < POS_MAX) begin
         pos_in = pos_ff + POS_W'(1);
         unique case (phase_ff)
            PH_HEADER: begin
               pass_valid = 1'b1;
               if (pos_ff == OFS_FLAGS_HI) begin
                  pass_byte = FLAG_QR | {7'b0, in_byte[0]};
                  if (in_byte[7]) begin
                     phase_in   = PH_REJECT;
                     pass_valid = 1'b0;
                  end
               end else if (pos_ff == OFS_FLAGS_LO) begin
                  pass_byte = FLAG_QR;
               end else if (pos_ff == OFS_QDCOUNT_HI) begin
                  qcz_in = (in_byte == 8'h00);
               end else if (pos_ff == OFS_QDCOUNT_LO) begin
                  qcz_in = qcz_ff && (in_byte == 8'h00);
               end else if (pos_ff == OFS_ANCOUNT_LO) begin
                  pass_byte = ANCOUNT_ONE;
               end else if (pos_ff >= OFS_ANCOUNT_HI) begin
                  pass_byte = 8'h00;
               end
               if (pos_ff == OFS_HDR_LAST) begin
                  phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               pass_valid = 1'b1;
               if (pos_ff == nlp_ff) begin
                  if (in_byte == 8'h00) begin
                     qend_in  = pos_ff + QTAIL_SPAN;
                     phase_in = PH_TAIL;
                  end else begin
                     nlp_in = pos_ff + POS_W'(in_byte) + POS_W'(1);
                  end
               end
            end
            PH_TAIL: begin
               pass_valid = 1'b1;
               if ((pos_ff + POS_W'(1)) >= qend_ff) begin
                  phase_in = PH_DONE;
               end
            end
            default: ;
         endcase
      end

      // Verdict on the packet as it stands after this byte.
      reply_ok = (phase_in == PH_DONE) && !qcz_in &&
                 (({1'b0, qend_in} + (POS_W + 1)'(ANSWER_LEN)) <= {1'b0, POS_MAX});

      // The final byte starts the next packet afresh.
      if (in_last) begin
         phase_in = PH_HEADER;
         pos_in   = '0;
         nlp_in   = HDR_LEN;
         qend_in  = '0;
         qcz_in   = 1'b0;
      end
   end

   assign parse.pass_valid = pass_valid;
   assign parse.pass_byte  = pass_byte;
   assign parse.last       = in_last;
   assign parse.ok         = reply_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         nlp_ff   <= HDR_LEN;
         qend_ff  <= '0;
         qcz_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         nlp_ff   <= nlp_in;
         qend_ff  <= qend_in;
         qcz_ff   <= qcz_in;
      end
   end

`ifndef ASSERT_OFF
   // The name walk only starts once the fixed header has gone by.
   a_name_after_header: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NAME) |-> (pos_ff >= HDR_LEN))
      else $error("name phase entered inside the header");

   // While the type and class bytes pass, the question end is still ahead.
   a_tail_ahead: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TAIL) |-> (pos_ff < qend_ff))
      else $error("tail phase past the question end");

   // The byte counter saturates at the packet limit.
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("byte position beyond the packet limit");
`endif

endmodule

>>> src/dcr_emitter.sv
`timescale 1ns / 1ps

module dcr_emitter
   import dcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  dcr_parse_type parse,
   input  logic [31:0]   answer_address,
   input  logic [31:0]   answer_ttl,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dcr_item_type  rsp_item
);

   logic            rsp_valid_ff, rsp_valid_in;
   dcr_item_type    item_ff, item_in;
   logic            trail_active_ff, trail_active_in;
   dcr_ans_idx_type trail_idx_ff, trail_idx_in;
   logic            trail_ok_ff, trail_ok_in;
   logic            load;

   // One byte of the trailer: the answer record, or the drop marker.
   function automatic dcr_item_type trailer_item(input dcr_ans_idx_type idx,
                                                 input logic ok,
                                                 input logic [31:0] addr,
                                                 input logic [31:0] ttl);
      dcr_item_type it;
      it.data = 8'h00;
      it.eor  = 1'b1;
      it.drop = 1'b1;
      if (ok) begin
         it.drop = 1'b0;
         it.eor  = (idx == ANS_IDX_LAST);
         case (idx)
            4'd0:    it.data = ANS_PTR_HI;
            4'd1:    it.data = ANS_PTR_LO;
            4'd3:    it.data = ANS_TYPE_A;
            4'd5:    it.data = ANS_CLASS_IN;
            4'd6:    it.data = ttl[31:24];
            4'd7:    it.data = ttl[23:16];
            4'd8:    it.data = ttl[15:8];
            4'd9:    it.data = ttl[7:0];
            4'd11:   it.data = ANS_RDLEN;
            4'd12:   it.data = addr[31:24];
            4'd13:   it.data = addr[23:16];
            4'd14:   it.data = addr[15:8];
            4'd15:   it.data = addr[7:0];
            default: it.data = 8'h00;
         endcase
      end
      return it;
   endfunction

   // The result register frees up when empty or when its item is taken.
   assign load      = !rsp_valid_ff || rsp_ready;
   assign req_ready = load && !trail_active_ff;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      item_in         = item_ff;
      trail_active_in = trail_active_ff;
      trail_idx_in    = trail_idx_ff;
      trail_ok_in     = trail_ok_ff;
      if (accept) begin
         if (parse.pass_valid) begin
            // Passed byte first; the trailer follows if this was the last one.
            rsp_valid_in    = 1'b1;
            item_in         = '{data: parse.pass_byte, eor: 1'b0, drop: 1'b0};
            trail_active_in = parse.last;
            trail_idx_in    = '0;
            trail_ok_in     = parse.ok;
         end else if (parse.last) begin
            // No byte to pass: the trailer starts at once.
            rsp_valid_in    = 1'b1;
            item_in         = trailer_item('0, parse.ok, answer_address, answer_ttl);
            trail_active_in = parse.ok;
            trail_idx_in    = ANS_IDX_W'(1);
            trail_ok_in     = parse.ok;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (load) begin
         if (trail_active_ff) begin
            rsp_valid_in    = 1'b1;
            item_in         = trailer_item(trail_idx_ff, trail_ok_ff,
                                           answer_address, answer_ttl);
            trail_active_in = trail_ok_ff && (trail_idx_ff != ANS_IDX_LAST);
            trail_idx_in    = trail_idx_ff + ANS_IDX_W'(1);
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         trail_active_ff <= 1'b0;
         trail_idx_ff    <= '0;
         trail_ok_ff     <= 1'b0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         trail_active_ff <= trail_active_in;
         trail_idx_ff    <= trail_idx_in;
         trail_ok_ff     <= trail_ok_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = item_ff;

`ifndef ASSERT_OFF
   // A drop marker is a single zero byte that closes the packet.
   a_drop_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && item_ff.drop) |-> (item_ff.eor && item_ff.data == 8'h00))
      else $error("malformed drop marker");

   // Loading the final answer byte ends the trailer.
   a_trailer_ends: assert property (@(posedge clock) disable iff (reset)
      (trail_active_ff && load && trail_idx_ff == ANS_IDX_LAST) |=> !trail_active_ff)
      else $error("trailer ran past the answer record");

   // No request is taken while a trailer is still being sent.
   a_no_req_in_trailer: assert property (@(posedge clock) disable iff (reset)
      $past(trail_active_ff) && trail_active_ff |-> !accept)
      else $error("request taken during the trailer");
`endif

endmodule

>>> src/captive_dns_responder.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                                   Handshake
// req_ch    in         in_byte[8], in_last                      valid/ready
// rsp_ch    out        out_byte[8], end_of_reply, reply_dropped valid/ready
// csr       in/out     APB: answer_address @0x0, answer_ttl @0x4 psel/penable
//
// A request byte is parsed in the cycle it is taken; any reply byte it yields
// sits in the result register on the next edge, at one byte per cycle while
// rsp_ch is ready. A packet's final byte adds a 16-byte answer record (or
// one drop marker), sent likewise from the result register; requests wait.
// Synchronous active-high reset clears all parse state and empties the output.
// A stalled result only holds off requests while the result register is full.

module captive_dns_responder
   import dcr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   dcr_req_if.sink           req_ch,
   dcr_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic          req_accept;
   logic          req_ready;
   logic [31:0]   answer_address;
   logic [31:0]   answer_ttl;
   dcr_parse_type parse;
   dcr_item_type  rsp_item;

   assign req_ch.ready = req_ready;
   assign req_accept   = req_ch.valid && req_ready;

   // Configuration registers.
   dcr_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .answer_address (answer_address),
      .answer_ttl     (answer_ttl)
   );

   // Query parser and header rewrite.
   dcr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept),
      .in_byte (req_ch.in_byte),
      .in_last (req_ch.in_last),
      .parse   (parse)
   );

   // Result register and answer trailer.
   dcr_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .parse          (parse),
      .answer_address (answer_address),
      .answer_ttl     (answer_ttl),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_item       (rsp_item)
   );

   assign rsp_ch.out_byte      = rsp_item.data;
   assign rsp_ch.end_of_reply  = rsp_item.eor;
   assign rsp_ch.reply_dropped = rsp_item.drop;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import dcr_pkg::*;

   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 80;

   // Predicts the reply stream of the responder and checks the bytes that leave it.
   class dns_reply_board;
      typedef enum logic [2:0] {
         ST_HEADER, ST_NAME, ST_TAIL, ST_DONE, ST_REJECT
      } parse_phase_e;

      logic [31:0]  answer_address;
      logic [31:0]  answer_ttl;
      dcr_pos_type  pos;
      dcr_pos_type  next_label;
      dcr_pos_type  question_end;
      parse_phase_e phase;
      logic         qd_zero;
      dcr_item_type pending_reply[$];
      int           errors;

      function new();
         answer_address = ANSWER_ADDRESS_RESET;
         answer_ttl     = ANSWER_TTL_RESET;
         errors         = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         pos          = '0;
         next_label   = HDR_LEN;
         question_end = '0;
         phase        = ST_HEADER;
         qd_zero      = 1'b0;
      endfunction

      function void set_register(logic idx, logic [31:0] value);
         if (idx == REG_ANSWER_ADDRESS) begin
            answer_address = value;
         end else begin
            answer_ttl = value;
         end
      endfunction

      function int outstanding();
         return pending_reply.size();
      endfunction

      function void queue_item(logic [7:0] d, logic eor, logic drop);
         pending_reply.push_back('{data: d, eor: eor, drop: drop});
      endfunction

      // Works out the reply bytes that one accepted request byte causes.
      function void note_request(logic [7:0] b, logic last);
         logic [7:0] o;
         logic [7:0] rec [ANSWER_LEN];
         o = b;
         if (pos < POS_MAX) begin
            case (phase)
               ST_HEADER: begin
                  if (pos == OFS_FLAGS_HI) begin
                     if (b[7]) phase = ST_REJECT;
                     o = FLAG_QR | {7'd0, b[0]};
                  end else if (pos == OFS_FLAGS_LO) begin
                     o = FLAG_QR;
                  end else if (pos == OFS_QDCOUNT_HI) begin
                     qd_zero = (b == 8'h00);
                  end else if (pos == OFS_QDCOUNT_LO) begin
                     qd_zero = qd_zero && (b == 8'h00);
                  end else if (pos == OFS_ANCOUNT_LO) begin
                     o = ANCOUNT_ONE;
                  end else if (pos >= OFS_ANCOUNT_HI) begin
                     o = 8'h00;
                  end
                  if (phase == ST_HEADER) begin
                     queue_item(o, 1'b0, 1'b0);
                     if (pos == OFS_HDR_LAST) phase = ST_NAME;
                  end
               end
               ST_NAME: begin
                  queue_item(b, 1'b0, 1'b0);
                  // Every byte at a label position is taken as a length, pointers too.
                  if (pos == next_label) begin
                     if (b == 8'h00) begin
                        question_end = pos + QTAIL_SPAN;
                        phase        = ST_TAIL;
                     end else begin
                        next_label = pos + dcr_pos_type'(b) + dcr_pos_type'(1);
                     end
                  end
               end
               ST_TAIL: begin
                  queue_item(b, 1'b0, 1'b0);
                  if (pos + dcr_pos_type'(1) >= question_end) phase = ST_DONE;
               end
               default: begin
               end
            endcase
            pos = pos + dcr_pos_type'(1);
         end
         if (last) begin
            if (phase == ST_DONE && !qd_zero &&
                int'(question_end) + ANSWER_LEN <= MAX_PACKET) begin
               rec = '{ANS_PTR_HI, ANS_PTR_LO, 8'h00, ANS_TYPE_A, 8'h00, ANS_CLASS_IN,
                       answer_ttl[31:24], answer_ttl[23:16], answer_ttl[15:8],
                       answer_ttl[7:0], 8'h00, ANS_RDLEN,
                       answer_address[31:24], answer_address[23:16],
                       answer_address[15:8], answer_address[7:0]};
               for (int i = 0; i < ANSWER_LEN; i++) begin
                  queue_item(rec[i], i == ANSWER_LEN - 1, 1'b0);
               end
            end else begin
               queue_item(8'h00, 1'b1, 1'b1);
            end
            clear_packet();
         end
      endfunction

      // Compares one reply byte with the oldest prediction.
      function void check_reply(dcr_item_type got);
         dcr_item_type want;
         if (pending_reply.size() == 0) begin
            $error("reply byte %02h arrived with nothing predicted", got.data);
            errors++;
            return;
         end
         want = pending_reply.pop_front();
         if (got.data !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, got.data);
            errors++;
         end
         if (got.eor !== want.eor) begin
            $error("end_of_reply: expected %0b, got %0b", want.eor, got.eor);
            errors++;
         end
         if (got.drop !== want.drop) begin
            $error("reply_dropped: expected %0b, got %0b", want.drop, got.drop);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   dcr_req_if req_ch ();
   dcr_rsp_if rsp_ch ();

   dns_reply_board reply_board = new();

   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_left;

   captive_dns_responder dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   // Reply side: a long hold-off when one is asked for, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_off_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(1, 100) > recv_stall_pct);
      end
   end

   // Both channels are observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            reply_board.note_request(req_ch.in_byte, req_ch.in_last);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            reply_board.check_reply('{data: rsp_ch.out_byte, eor: rsp_ch.end_of_reply,
                                      drop: rsp_ch.reply_dropped});
         end
      end
   end

   // Ends the run if nothing moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || psel || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("** captive_dns_responder: FAILED **");
      $finish;
   end

   // Offers one request byte, idling first at random, and waits until it is taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.in_byte = b;
      req_ch.in_last = last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_packet(input logic [7:0] pkt[$]);
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   // Writes a register and reads it back, psel held high across both transfers.
   task automatic csr_write(input logic idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      reply_board.set_register(idx, value);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (readback !== value) begin
         $error("prdata: expected %08h, got %08h", value, readback);
         reply_board.errors++;
      end
   endtask

   // Stops offering requests and waits until the block has nothing left to send.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (reply_board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Builds a query: header, a name whose labels span the given number of bytes,
   // the root label, type and class, then any trailing bytes.
   function automatic void make_query(ref logic [7:0] pkt[$], input int span,
                                      input int extra, input int max_chunk);
      int chunk;
      pkt.delete();
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 127)));
      pkt.push_back(8'($urandom_range(0, 255)));
      // Question count is mostly one; now and then any value, zero included.
      pkt.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
      pkt.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h01);
      repeat (6) pkt.push_back(8'($urandom()));
      // A remainder of one byte would read as the root label, so it is folded in.
      while (span > 0) begin
         chunk = $urandom_range(2, max_chunk);
         if (chunk > span) chunk = span;
         if (span - chunk == 1) chunk++;
         pkt.push_back(8'(chunk - 1));
         repeat (chunk - 1) pkt.push_back(8'($urandom()));
         span -= chunk;
      end
      pkt.push_back(8'h00);
      repeat (4 + extra) pkt.push_back(8'($urandom()));
   endfunction

   // Mostly well-formed queries with random content; the rest broken or noise.
   task automatic run_random(input int budget, input int hold_cycles);
      logic [7:0] pkt[$];
      int sent;
      int kind;
      int span;
      int cut;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 99);
         span = $urandom_range(0, 30);
         if (span == 1) span = 2;
         make_query(pkt, span, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0, 12);
         if (kind >= 60 && kind < 70) begin
            pkt[OFS_FLAGS_HI] = pkt[OFS_FLAGS_HI] | FLAG_QR;
         end else if (kind >= 70 && kind < 78) begin
            pkt[OFS_QDCOUNT_HI] = 8'h00;
            pkt[OFS_QDCOUNT_LO] = 8'h00;
         end else if (kind >= 78 && kind < 88) begin
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut) pkt.delete(pkt.size() - 1);
         end else if (kind >= 88 && kind < 92) begin
            // A name pointer in the first label is read as a length of 192.
            pkt[HDR_LEN] = ANS_PTR_HI;
         end else if (kind >= 92) begin
            pkt.delete();
            repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom()));
         end
         send_packet(pkt);
         if (sent == 0 && hold_cycles > 0) hold_off_left = hold_cycles;
         sent += pkt.size();
      end
   endtask

   initial begin
      logic [7:0] pkt[$];
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      req_ch.in_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_left  = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed: smallest acceptable query with RD set and header bytes at their top
      // value, a packet of one byte, and a query with the response bit set.
      pkt = '{8'hFF, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01};
      send_packet(pkt);
      pkt = '{8'h00};
      send_packet(pkt);
      pkt = '{8'h00, 8'h00, 8'hFF};
      send_packet(pkt);
      wait_drained();

      // No idling, with a long hold-off on the reply side early on.
      csr_write(REG_ANSWER_ADDRESS, 32'h0000_0000);
      csr_write(REG_ANSWER_TTL, 32'hFFFF_FFFF);
      run_random(90, HOLD_CYCLES);
      wait_drained();

      // Sender idle most of the time.
      csr_write(REG_ANSWER_ADDRESS, 32'hFFFF_FFFF);
      csr_write(REG_ANSWER_TTL, 32'h0000_0000);
      send_idle_pct = 66;
      run_random(90, 0);
      wait_drained();

      // Receiver stalling most of the time.
      csr_write(REG_ANSWER_ADDRESS, $urandom());
      csr_write(REG_ANSWER_TTL, $urandom());
      send_idle_pct  = 0;
      recv_stall_pct = 66;
      run_random(90, 0);
      wait_drained();

      // Both sides idling.
      csr_write(REG_ANSWER_ADDRESS, $urandom());
      csr_write(REG_ANSWER_TTL, $urandom());
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      run_random(90, 0);
      wait_drained();

      if (reply_board.errors == 0) begin
         $display("** captive_dns_responder: PASSED **");
      end else begin
         $display("** captive_dns_responder: FAILED **");
      end
      $finish;
   end

endmodule
